// ===== rtl/core/smcn_pkg.sv =====
// Shared types and constants for the sensor min/max calibrate and normalise core
package smcn_pkg;

    localparam int RAW_W  = 10;
    localparam int NORM_W = 10;
    localparam int KIND_W = 2;
    localparam int CNT_W  = 4;
    localparam int DIFF_W = 16;
    localparam int NUM_W  = 21;
    localparam logic [NORM_W-1:0] NORM_TOP = 10'd1000;
    localparam logic [RAW_W-1:0]  FULL_SCALE_RESET = 10'd1023;

    typedef enum logic [KIND_W-1:0] {
        KIND_CAL_RESET = 2'd0,
        KIND_CAL_READ  = 2'd1,
        KIND_NORMALISE = 2'd2,
        KIND_IGNORE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    // Control from the top level to every lane
    typedef struct packed {
        logic cal_reset;
        logic cal_read;
        logic first_read;
        logic last_read;
        logic div_start;
    } lane_ctrl_t;

endpackage

// ===== rtl/core/smcn_if.sv =====
// Valid/ready stream interface carrying one payload
interface smcn_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sensor_minmax_calibrate_normalize_core.sv =====
// Top level: handshakes, pass sequencing, lane array and result register
// Six lanes, one per sensor channel, each keeps its own calibration marks
// and divides (raw - low) * 1000 by (high - low) mod 65536 with a radix-2
// restoring divider. A normalise transaction runs from acceptance through
// set-up and a 21-bit quotient to the result register; calibration
// transactions finish on acceptance. One transaction is handled at a time;
// a new one is accepted when the result register has been emptied.
// full_scale should be written only while the core is idle.
module sensor_minmax_calibrate_normalize_core
    import smcn_pkg::*;
#(
    parameter int CHANNELS = 6,
    parameter int READINGS_PER_PASS = 10
)
(
    input logic clk,
    input logic rst_n,
    smcn_if.sink   cfg,
    smcn_if.sink   in_ch,
    smcn_if.source out_ch
);

    localparam int CW = $clog2(NUM_W + 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     step_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [RAW_W-1:0]  fs_reg;
    logic [RAW_W-1:0]  raw_ch [CHANNELS];
    logic [NORM_W-1:0] norm [CHANNELS];
    logic [NORM_W-1:0] res_reg [CHANNELS];
    lane_ctrl_t        ctrl;
    logic              accept;
    kind_t             kind;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_OUT);
    assign accept = in_ch.valid && in_ch.ready;
    assign kind = kind_t'(in_ch.data[KIND_W-1:0]);

    // Lane control
    always_comb
    begin
        ctrl.cal_reset  = accept && kind == KIND_CAL_RESET;
        ctrl.cal_read   = accept && kind == KIND_CAL_READ;
        ctrl.first_read = (count_reg == '0);
        ctrl.last_read  = (count_reg == CNT_W'(READINGS_PER_PASS - 1));
        ctrl.div_start  = (state_reg == ST_IDLE);
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fs_reg <= FULL_SCALE_RESET;
        else if (cfg.valid)
            fs_reg <= cfg.data[RAW_W-1:0];
    end

    // Pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.cal_read)
            count_reg <= ctrl.last_read ? '0 : count_reg + 1'b1;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_reg == ST_DIV) ? step_reg + 1'b1 : '0;
        end
    end

    // step_reg counts the divider iterations already done
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && kind == KIND_NORMALISE) state_next = ST_DIV;
            ST_DIV:  if (step_reg == CW'(NUM_W)) state_next = ST_OUT;
            ST_OUT:  if (out_ch.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Lanes and result merge
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        assign raw_ch[c] = in_ch.data[KIND_W + c*RAW_W +: RAW_W];

        smcn_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .raw        (raw_ch[c]),
            .full_scale (fs_reg),
            .norm       (norm[c])
        );

        always_ff @(posedge clk)
        begin
            if (state_reg == ST_DIV && step_reg == CW'(NUM_W))
                res_reg[c] <= norm[c];
        end

        assign out_ch.data[c*NORM_W +: NORM_W] = res_reg[c];
    end

endmodule

// ===== rtl/core/smcn_lane.sv =====
// One channel lane: pass extremes, calibration marks and a radix-2 divider
module smcn_lane
    import smcn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctrl_t        ctrl,
    input  logic [RAW_W-1:0]  raw,
    input  logic [RAW_W-1:0]  full_scale,
    output logic [NORM_W-1:0] norm
);

    logic [RAW_W-1:0] low_reg, high_reg;
    logic [RAW_W-1:0] pass_lo_reg, pass_hi_reg;
    logic [RAW_W-1:0] pass_lo_next, pass_hi_next;
    logic [RAW_W-1:0] cap;
    logic [NUM_W-1:0] quot_reg;
    logic [DIFF_W:0]  rem_reg;
    logic [DIFF_W-1:0] div_reg;
    logic             zero_reg, neg_reg;
    logic [DIFF_W-1:0] diff;
    logic signed [RAW_W+1:0] delta;
    logic [NUM_W-1:0] num;
    logic [DIFF_W:0]  rem_shift;

    // Pass extremes including the current reading
    always_comb
    begin
        pass_lo_next = (ctrl.first_read || raw < pass_lo_reg) ? raw : pass_lo_reg;
        pass_hi_next = (ctrl.first_read || raw > pass_hi_reg) ? raw : pass_hi_reg;
        cap = (pass_hi_next < full_scale) ? pass_hi_next : full_scale;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cal_read)
        begin
            pass_lo_reg <= pass_lo_next;
            pass_hi_reg <= pass_hi_next;
        end
    end

    // Calibration marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= FULL_SCALE_RESET;
            high_reg <= '0;
        end
        else if (ctrl.cal_reset)
        begin
            low_reg  <= full_scale;
            high_reg <= '0;
        end
        else if (ctrl.cal_read && ctrl.last_read)
        begin
            low_reg  <= cap;
            high_reg <= pass_lo_next;
        end
    end

    // Numerator and divisor set-up
    always_comb
    begin
        diff  = DIFF_W'({6'd0, high_reg} - {6'd0, low_reg});
        delta = $signed({2'b00, raw}) - $signed({2'b00, low_reg});
        num   = NUM_W'(delta[RAW_W-1:0]) * NUM_W'(NORM_TOP);
        rem_shift = {rem_reg[DIFF_W-1:0], quot_reg[NUM_W-1]};
    end

    // Restoring divider, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.div_start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            div_reg  <= diff;
            zero_reg <= (diff == '0);
            neg_reg  <= delta[RAW_W+1];
        end
        else if (rem_shift >= {1'b0, div_reg})
        begin
            rem_reg  <= rem_shift - {1'b0, div_reg};
            quot_reg <= {quot_reg[NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_reg  <= rem_shift;
            quot_reg <= {quot_reg[NUM_W-2:0], 1'b0};
        end
    end

    // Clamp to 0..1000
    always_comb
    begin
        if (zero_reg || neg_reg)
            norm = '0;
        else if (quot_reg > NUM_W'(NORM_TOP))
            norm = NORM_TOP;
        else
            norm = quot_reg[NORM_W-1:0];
    end

endmodule

// ===== test/sensor_minmax_calibrate_normalize_core_tb.sv =====
// Testbench for the sensor min/max calibrate and normalise core
`timescale 1ns / 100ps

module sensor_minmax_calibrate_normalize_core_tb;
    import smcn_pkg::*;

    localparam int NCH     = 6;
    localparam int PASS_N  = 10;
    localparam int IN_W    = KIND_W + NCH * RAW_W;
    localparam int OUT_W   = NCH * NORM_W;
    localparam int SETTLE  = 40;      // longer than one normalise transaction

    typedef logic [RAW_W-1:0] raw_vec_t [NCH];

    // Calibration state mirror plus queue of pending normalised vectors
    class norm_scoreboard;
        logic [RAW_W-1:0]  full_scale;
        logic [RAW_W-1:0]  low_mark [NCH];
        logic [RAW_W-1:0]  high_mark [NCH];
        logic [RAW_W-1:0]  pass_min [NCH];
        logic [RAW_W-1:0]  pass_max [NCH];
        int unsigned       reads_taken;
        logic [OUT_W-1:0]  pending_norm [$];
        int unsigned       mismatches;
        int unsigned       errors;

        function new();
            full_scale  = FULL_SCALE_RESET;
            reads_taken = 0;
            mismatches  = 0;
            errors      = 0;
            for (int c = 0; c < NCH; c++)
            begin
                low_mark[c]  = FULL_SCALE_RESET;
                high_mark[c] = '0;
                pass_min[c]  = '0;
                pass_max[c]  = '0;
            end
        endfunction

        function void set_full_scale(logic [RAW_W-1:0] v);
            full_scale = v;
        endfunction

        // (raw - low) * 1000 / ((high - low) mod 2^16), clamped to 0..1000
        function logic [NORM_W-1:0] scale(logic [RAW_W-1:0] raw,
                                          logic [RAW_W-1:0] lo,
                                          logic [RAW_W-1:0] hi);
            int span;
            longint num;
            longint quo;
            span = (int'(hi) - int'(lo)) & 32'hFFFF;
            if (span == 0)
                return '0;
            num = (longint'(raw) - longint'(lo)) * 1000;
            quo = num / longint'(span);
            if (quo < 0)
                quo = 0;
            else if (quo > 1000)
                quo = 1000;
            return quo[NORM_W-1:0];
        endfunction

        function void note_input(kind_t kind, raw_vec_t raw);
            logic [OUT_W-1:0] norm;
            case (kind)
                KIND_CAL_RESET:
                begin
                    for (int c = 0; c < NCH; c++)
                    begin
                        low_mark[c]  = full_scale;
                        high_mark[c] = '0;
                    end
                end
                KIND_CAL_READ:
                begin
                    for (int c = 0; c < NCH; c++)
                    begin
                        if (reads_taken == 0 || raw[c] > pass_max[c])
                            pass_max[c] = raw[c];
                        if (reads_taken == 0 || raw[c] < pass_min[c])
                            pass_min[c] = raw[c];
                    end
                    reads_taken++;
                    if (reads_taken >= PASS_N)
                    begin
                        for (int c = 0; c < NCH; c++)
                        begin
                            high_mark[c] = pass_min[c];
                            low_mark[c]  = (pass_max[c] < full_scale) ? pass_max[c]
                                                                      : full_scale;
                        end
                        reads_taken = 0;
                    end
                end
                KIND_NORMALISE:
                begin
                    for (int c = 0; c < NCH; c++)
                        norm[c*NORM_W +: NORM_W] = scale(raw[c], low_mark[c], high_mark[c]);
                    pending_norm.push_back(norm);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (pending_norm.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending_norm.pop_front();
            for (int c = 0; c < NCH; c++)
            begin
                if (got[c*NORM_W +: NORM_W] !== want[c*NORM_W +: NORM_W])
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("norm_%0d mismatch: expected %0d, got %0d", c,
                                 want[c*NORM_W +: NORM_W], got[c*NORM_W +: NORM_W]);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    smcn_if #(.W(RAW_W)) cfg_if ();
    smcn_if #(.W(IN_W))  in_if ();
    smcn_if #(.W(OUT_W)) out_if ();

    sensor_minmax_calibrate_normalize_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    norm_scoreboard sb = new();

    bit          no_idle;        // sender and receiver both run flat out
    int unsigned hold_request;   // receiver hold-off length, taken by receiver
    int unsigned results_seen;

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        results_seen = 0;
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_if.valid && out_if.ready)
            begin
                sb.check_result(out_if.data);
                results_seen++;
            end
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 30);
        end
    end

    // Register write, only with nothing outstanding
    task automatic write_full_scale(logic [RAW_W-1:0] v);
        wait (sb.pending_norm.size() == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.set_full_scale(v);
        cfg_if.valid <= 1'b0;
    endtask

    // One input transaction, with a random idle gap first
    task automatic send_item(kind_t kind, raw_vec_t raw);
        logic [IN_W-1:0] word;
        int unsigned gap;
        word[KIND_W-1:0] = kind;
        for (int c = 0; c < NCH; c++)
            word[KIND_W + c*RAW_W +: RAW_W] = raw[c];
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 30)
            gap = $urandom_range(1, 6);
        if (gap != 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= word;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.note_input(kind, raw);
    endtask

    task automatic send_fill(kind_t kind, logic [RAW_W-1:0] v);
        raw_vec_t raw;
        for (int c = 0; c < NCH; c++)
            raw[c] = v;
        send_item(kind, raw);
    endtask

    task automatic send_random(kind_t kind);
        raw_vec_t raw;
        for (int c = 0; c < NCH; c++)
            raw[c] = $urandom_range(0, 1023);
        send_item(kind, raw);
    endtask

    // A calibration pass; flat passes give equal marks (zero span) unless full_scale is below the reading
    task automatic cal_pass(bit flat);
        raw_vec_t raw;
        raw_vec_t base;
        for (int c = 0; c < NCH; c++)
            base[c] = $urandom_range(0, 1023);
        for (int n = 0; n < PASS_N; n++)
        begin
            for (int c = 0; c < NCH; c++)
                raw[c] = flat ? base[c] : RAW_W'($urandom_range(0, 1023));
            send_item(KIND_CAL_READ, raw);
        end
    endtask

    // Stimulus
    initial
    begin
        int unsigned sent;
        int unsigned pick;
        bit          hold_done;
        bit          pause_done;
        rst_n = 1'b0;
        no_idle = 1'b0;
        hold_request = 0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset marks (inverted, wrapped span), ignored kind, extremes
        send_fill(KIND_NORMALISE, 10'd0);
        send_fill(KIND_NORMALISE, 10'd1023);
        send_fill(KIND_IGNORE, 10'd1023);
        send_fill(KIND_NORMALISE, 10'd512);
        // Pass with extremes; a calibration reset in its middle does not restart the pass
        for (int n = 0; n < 5; n++)
            send_fill(KIND_CAL_READ, (n % 2) ? 10'd1023 : 10'd0);
        send_fill(KIND_CAL_RESET, 10'd0);
        for (int n = 0; n < 5; n++)
            send_fill(KIND_CAL_READ, 10'd300 + 10'(n));
        send_fill(KIND_NORMALISE, 10'd0);
        send_fill(KIND_NORMALISE, 10'd1023);
        send_fill(KIND_NORMALISE, 10'd302);
        send_fill(KIND_CAL_RESET, 10'd1023);
        send_fill(KIND_NORMALISE, 10'd1000);

        // Random phases under several full-scale settings
        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            in_if.valid <= 1'b0;
            case (phase)
                0: write_full_scale(10'd0);
                1: write_full_scale(RAW_W'($urandom_range(1, 1022)));
                2: write_full_scale(10'd1023);
                default: write_full_scale(10'd500);
            endcase
            while (sent < (phase + 1) * 500)
            begin
                no_idle = (sent >= 200 && sent < 400);
                if (sent >= 700 && !hold_done)
                begin
                    hold_request = 400;
                    hold_done = 1'b1;
                end
                if (sent >= 1100 && !pause_done)
                begin
                    in_if.valid <= 1'b0;
                    wait (sb.pending_norm.size() == 0);
                    pause_done = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    cal_pass(pick < 4);
                    sent += PASS_N;
                end
                else if (pick < 90)
                begin
                    send_random(KIND_NORMALISE);
                    sent++;
                end
                else if (pick < 95)
                begin
                    send_random(KIND_CAL_RESET);
                    sent++;
                end
                else if (pick < 98)
                    send_random(KIND_CAL_READ);
                else
                    send_random(KIND_IGNORE);
            end
        end
        in_if.valid <= 1'b0;
        no_idle = 1'b0;

        // Drain
        wait (sb.pending_norm.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
